### rtl/elastic_collision_3d_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elastic collision block.
// Each macro checks an implication on the rising clock edge, with a reset.
// ----------------------------------------------------------------------------
`ifndef ELASTIC_COLLISION_3D_MACROS_SVH
`define ELASTIC_COLLISION_3D_MACROS_SVH
`ifndef ASSERT_OFF
`define EC3_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define EC3_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define EC3_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define EC3_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/ec3_pkg.sv
// ----------------------------------------------------------------------------
// ec3_pkg
// Widths, item types and output saturation for the elastic collision block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ec3_pkg;

   localparam int W       = 32;
   localparam int TAGW    = 32;
   localparam int MASSW   = W - 1;
   localparam int EW      = W + 1;
   localparam int SQW     = 2 * W;
   localparam int PRW     = W + EW;
   localparam int SSW     = 2 * W + 2;
   localparam int PW      = 2 * W + 3;
   localparam int PMW     = 2 * W + 2;
   localparam int MW      = W;
   localparam int DENW    = MW + SSW;
   localparam int CW      = MW + PMW;
   localparam int TW      = CW + W;
   localparam int NW      = TW + 2;
   localparam int DW      = DENW + 1;
   localparam int QB      = W + 3;
   localparam int QSW     = QB + 2;
   localparam int DIV_LAT = QB + 2;
   localparam int CYL     = 4 + DIV_LAT;

   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [TAGW-1:0]   pair_tag;
      logic signed [W-1:0] offset_x;
      logic signed [W-1:0] offset_y;
      logic signed [W-1:0] offset_z;
      logic signed [W-1:0] a_vel_x;
      logic signed [W-1:0] a_vel_y;
      logic signed [W-1:0] a_vel_z;
      logic signed [W-1:0] b_vel_x;
      logic signed [W-1:0] b_vel_y;
      logic signed [W-1:0] b_vel_z;
      logic [MASSW-1:0]  mass_a;
      logic [MASSW-1:0]  mass_b;
   } req_type;

   typedef struct packed {
      logic [TAGW-1:0]   tag_out;
      logic signed [W-1:0] new_a_vel_x;
      logic signed [W-1:0] new_a_vel_y;
      logic signed [W-1:0] new_a_vel_z;
      logic signed [W-1:0] new_b_vel_x;
      logic signed [W-1:0] new_b_vel_y;
      logic signed [W-1:0] new_b_vel_z;
      logic              degenerate;
   } rsp_type;

   typedef struct packed {
      logic [TAGW-1:0]   tag;
      logic [2:0][W-1:0] va;
      logic [2:0][W-1:0] vb;
      logic [2:0][W-1:0] dm;
      logic [2:0]        dn;
      logic [MW-1:0]     msum;
      logic [MW-1:0]     ma2;
      logic [MW-1:0]     mb2;
   } head_type;

   typedef struct packed {
      logic [TAGW-1:0]   tag;
      logic [2:0][W-1:0] va;
      logic [2:0][W-1:0] vb;
      logic [2:0][W-1:0] dm;
      logic [2:0]        dn;
      logic              pn;
      logic              bypass;
      logic              degen;
   } tail_type;

   function automatic logic [W-1:0] sat_out(input logic [W-1:0] v, input logic neg,
                                            input logic [QB-1:0] q, input logic ovf,
                                            input logic bypass);
      logic signed [QSW-1:0] qs;
      logic signed [QSW-1:0] sum;
      logic [W-1:0]          r;
      qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      sum = QSW'($signed(v)) + qs;
      if (bypass) begin
         r = v;
      end else if (ovf) begin
         r = neg ? SMIN : SMAX;
      end else if (sum[QSW-1:W-1] == '0 || sum[QSW-1:W-1] == '1) begin
         r = sum[W-1:0];
      end else begin
         r = sum[QSW-1] ? SMIN : SMAX;
      end
      return r;
   endfunction

endpackage

### rtl/ec3_mul.sv
// ----------------------------------------------------------------------------
// ec3_mul
// Two-stage unsigned multiplier: partial products of 32-bit slices of a, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ec3_mul #(
   parameter int AW = 66,
   parameter int BW = 32
) (
   input  logic            clock,
   input  logic            en,
   input  logic [AW-1:0]   a,
   input  logic [BW-1:0]   b,
   output logic [AW+BW-1:0] p
);
   localparam int CH  = 32;
   localparam int NCH = (AW + CH - 1) / CH;
   localparam int PPW = CH + BW;

   logic [NCH*CH-1:0]         a_pad;
   logic [NCH-1:0][PPW-1:0]   pp_ff;
   logic [AW+BW-1:0]          p_in;
   logic [AW+BW-1:0]          p_ff;

   assign a_pad = (NCH*CH)'(a);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NCH; i++) begin
            pp_ff[i] <= a_pad[i*CH +: CH] * b;
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NCH; i++) begin
         p_in = p_in + ((AW+BW)'(pp_ff[i]) << (i * CH));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

### rtl/ec3_rdiv.sv
// ----------------------------------------------------------------------------
// ec3_rdiv
// Pipelined restoring divider giving round(num / den), ties away from zero,
// one quotient bit per stage, with a flag for quotients out of range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ec3_rdiv (
   input  logic                    clock,
   input  logic                    en,
   input  logic [ec3_pkg::TW-1:0]  num,
   input  logic [ec3_pkg::DENW-1:0] den,
   output logic [ec3_pkg::QB-1:0]  quo,
   output logic                    ovf
);
   import ec3_pkg::*;

   logic [NW-1:0] n_ff;
   logic [DW-1:0] d0_ff;
   logic [DW-1:0] rem_ff [QB];
   logic [DW-1:0] dv_ff  [QB];
   logic [QB-1:0] nl_ff  [QB];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ov_ff  [QB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff  <= NW'({num, 1'b0}) + NW'(den);
         d0_ff <= {den, 1'b0};
         rem_ff[0] <= DW'(n_ff[NW-1:QB]);
         ov_ff[0]  <= DW'(n_ff[NW-1:QB]) >= d0_ff;
         dv_ff[0]  <= d0_ff;
         nl_ff[0]  <= n_ff[QB-1:0];
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DW:0]   r2;
      logic [DW:0]   diff;
      logic          ge;
      logic [QB-1:0] q_in;

      assign r2   = {rem_ff[k-1], nl_ff[k-1][QB-k]};
      assign diff = r2 - {1'b0, dv_ff[k-1]};
      assign ge   = r2 >= {1'b0, dv_ff[k-1]};

      always_comb begin
         q_in       = q_ff[k-1];
         q_in[QB-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]  <= q_in;
            ov_ff[k] <= ov_ff[k-1];
         end
      end

      if (k < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
               dv_ff[k]  <= dv_ff[k-1];
               nl_ff[k]  <= nl_ff[k-1];
            end
         end
      end
   end

   assign quo = q_ff[QB];
   assign ovf = ov_ff[QB];

endmodule

### rtl/elastic_collision_3d.sv
// ----------------------------------------------------------------------------
// elastic_collision_3d
// Throughput: one item per cycle; the pipeline moves as a whole and halts
// only while the output register holds a result that is not taken.
// The depth is set by the multipliers and the divider, one quotient bit per divider stage.
// Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elastic_collision_3d_macros.svh"

module elastic_collision_3d (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ec3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ec3_pkg::rsp_type rsp_data
);
   import ec3_pkg::*;

   logic en;

   logic [2:0][W-1:0] in_d;
   logic [2:0][W-1:0] in_va;
   logic [2:0][W-1:0] in_vb;
   head_type          head_in;
   logic [2:0][EW-1:0] e_in;

   logic              s1_valid_ff;
   head_type          s1_hd_ff;
   logic [2:0][W-1:0] s1_d_ff;
   logic [2:0][EW-1:0] s1_e_ff;

   logic              s2_valid_ff;
   head_type          s2_hd_ff;
   logic [2:0][SQW-1:0] s2_sq_ff;
   logic [2:0][PRW-1:0] s2_pr_ff;

   logic              s3_valid_ff;
   head_type          s3_hd_ff;
   logic [SSW-1:0]    s3_ss_ff;
   logic [PW-1:0]     s3_p_ff;

   logic              s4_valid_ff;
   head_type          s4_hd_ff;
   logic [SSW-1:0]    s4_ss_ff;
   logic [PMW-1:0]    s4_pm_ff;
   logic              s4_pn_ff;
   logic              s4_bypass_ff;
   logic              s4_degen_ff;
   logic [PW-1:0]     pneg;

   tail_type          tail_in;
   tail_type          cy_ff [CYL];
   logic              vl_ff [CYL];

   logic [DENW-1:0]   den_w;
   logic [CW-1:0]     ca_w;
   logic [CW-1:0]     cb_w;
   logic [DENW-1:0]   den_d_ff [2];

   logic [2:0][TW-1:0] ta_w;
   logic [2:0][TW-1:0] tb_w;
   logic [2:0][QB-1:0] qa;
   logic [2:0][QB-1:0] qb;
   logic [2:0]         ova;
   logic [2:0]         ovb;
   logic [2:0][W-1:0]  na;
   logic [2:0][W-1:0]  nb;

   rsp_type           out_in;
   rsp_type           out_ff;
   logic              rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      in_d[0]  = req_data.offset_x;
      in_d[1]  = req_data.offset_y;
      in_d[2]  = req_data.offset_z;
      in_va[0] = req_data.a_vel_x;
      in_va[1] = req_data.a_vel_y;
      in_va[2] = req_data.a_vel_z;
      in_vb[0] = req_data.b_vel_x;
      in_vb[1] = req_data.b_vel_y;
      in_vb[2] = req_data.b_vel_z;
      head_in.tag  = req_data.pair_tag;
      head_in.va   = in_va;
      head_in.vb   = in_vb;
      head_in.msum = MW'(req_data.mass_a) + MW'(req_data.mass_b);
      head_in.ma2  = {req_data.mass_a, 1'b0};
      head_in.mb2  = {req_data.mass_b, 1'b0};
      for (int k = 0; k < 3; k++) begin
         head_in.dn[k] = in_d[k][W-1];
         head_in.dm[k] = in_d[k][W-1] ? (~in_d[k] + W'(1)) : in_d[k];
         e_in[k] = EW'($signed(in_vb[k])) - EW'($signed(in_va[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CYL; i++) begin
            vl_ff[i] <= 1'b0;
         end
      end else if (en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         vl_ff[0]     <= s4_valid_ff;
         for (int i = 1; i < CYL; i++) begin
            vl_ff[i] <= vl_ff[i-1];
         end
         rsp_valid_ff <= vl_ff[CYL-1];
      end
   end

   assign pneg = ~s3_p_ff + PW'(1);

   always_comb begin
      tail_in.tag    = s4_hd_ff.tag;
      tail_in.va     = s4_hd_ff.va;
      tail_in.vb     = s4_hd_ff.vb;
      tail_in.dm     = s4_hd_ff.dm;
      tail_in.dn     = s4_hd_ff.dn;
      tail_in.pn     = s4_pn_ff;
      tail_in.bypass = s4_bypass_ff;
      tail_in.degen  = s4_degen_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_hd_ff <= head_in;
         s1_d_ff  <= in_d;
         s1_e_ff  <= e_in;

         s2_hd_ff <= s1_hd_ff;
         for (int k = 0; k < 3; k++) begin
            s2_sq_ff[k] <= SQW'($signed(s1_d_ff[k]) * $signed(s1_d_ff[k]));
            s2_pr_ff[k] <= PRW'($signed(s1_d_ff[k]) * $signed(s1_e_ff[k]));
         end

         s3_hd_ff <= s2_hd_ff;
         s3_ss_ff <= SSW'(s2_sq_ff[0]) + SSW'(s2_sq_ff[1]) + SSW'(s2_sq_ff[2]);
         s3_p_ff  <= PW'($signed(s2_pr_ff[0])) + PW'($signed(s2_pr_ff[1]))
                     + PW'($signed(s2_pr_ff[2]));

         s4_hd_ff     <= s3_hd_ff;
         s4_ss_ff     <= s3_ss_ff;
         s4_pn_ff     <= s3_p_ff[PW-1];
         s4_pm_ff     <= PMW'(s3_p_ff[PW-1] ? pneg : s3_p_ff);
         s4_bypass_ff <= (s3_ss_ff == '0) || (s3_hd_ff.msum == '0);
         s4_degen_ff  <= (s3_ss_ff == '0);

         cy_ff[0] <= tail_in;
         for (int i = 1; i < CYL; i++) begin
            cy_ff[i] <= cy_ff[i-1];
         end

         den_d_ff[0] <= den_w;
         den_d_ff[1] <= den_d_ff[0];

         out_ff <= out_in;
      end
   end

   ec3_mul #(.AW(SSW), .BW(MW)) u_mul_den (
      .clock (clock),
      .en    (en),
      .a     (s4_ss_ff),
      .b     (s4_hd_ff.msum),
      .p     (den_w)
   );

   ec3_mul #(.AW(PMW), .BW(MW)) u_mul_ca (
      .clock (clock),
      .en    (en),
      .a     (s4_pm_ff),
      .b     (s4_hd_ff.mb2),
      .p     (ca_w)
   );

   ec3_mul #(.AW(PMW), .BW(MW)) u_mul_cb (
      .clock (clock),
      .en    (en),
      .a     (s4_pm_ff),
      .b     (s4_hd_ff.ma2),
      .p     (cb_w)
   );

   for (genvar k = 0; k < 3; k++) begin : g_axis
      ec3_mul #(.AW(CW), .BW(W)) u_mul_ta (
         .clock (clock),
         .en    (en),
         .a     (ca_w),
         .b     (cy_ff[1].dm[k]),
         .p     (ta_w[k])
      );

      ec3_mul #(.AW(CW), .BW(W)) u_mul_tb (
         .clock (clock),
         .en    (en),
         .a     (cb_w),
         .b     (cy_ff[1].dm[k]),
         .p     (tb_w[k])
      );

      ec3_rdiv u_div_a (
         .clock (clock),
         .en    (en),
         .num   (ta_w[k]),
         .den   (den_d_ff[1]),
         .quo   (qa[k]),
         .ovf   (ova[k])
      );

      ec3_rdiv u_div_b (
         .clock (clock),
         .en    (en),
         .num   (tb_w[k]),
         .den   (den_d_ff[1]),
         .quo   (qb[k]),
         .ovf   (ovb[k])
      );

      assign na[k] = sat_out(cy_ff[CYL-1].va[k], cy_ff[CYL-1].pn ^ cy_ff[CYL-1].dn[k],
                             qa[k], ova[k], cy_ff[CYL-1].bypass);
      assign nb[k] = sat_out(cy_ff[CYL-1].vb[k], ~cy_ff[CYL-1].pn ^ cy_ff[CYL-1].dn[k],
                             qb[k], ovb[k], cy_ff[CYL-1].bypass);
   end

   always_comb begin
      out_in.tag_out     = cy_ff[CYL-1].tag;
      out_in.new_a_vel_x = na[0];
      out_in.new_a_vel_y = na[1];
      out_in.new_a_vel_z = na[2];
      out_in.new_b_vel_x = nb[0];
      out_in.new_b_vel_y = nb[1];
      out_in.new_b_vel_z = nb[2];
      out_in.degenerate  = cy_ff[CYL-1].degen;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

   `EC3_ASSERT_NXT(a_stall_keeps_item, clock, reset, vl_ff[CYL-1] && !en, vl_ff[CYL-1])
   `EC3_ASSERT_NXT(a_ovf_saturates, clock, reset,
      en && vl_ff[CYL-1] && !cy_ff[CYL-1].bypass && ova[0],
      rsp_data.new_a_vel_x == SMAX || rsp_data.new_a_vel_x == SMIN)
   `EC3_ASSERT_NXT(a_degen_passes_b, clock, reset, en && vl_ff[CYL-1] && cy_ff[CYL-1].degen,
      rsp_data.degenerate && rsp_data.new_b_vel_z == $past(cy_ff[CYL-1].vb[2]))
   `EC3_ASSERT_IMP(a_degen_bypass, clock, reset, vl_ff[CYL-1] && cy_ff[CYL-1].degen,
      cy_ff[CYL-1].bypass)

endmodule

### tb/sv/tb_elastic_collision_3d.sv
// ----------------------------------------------------------------------------
// tb_elastic_collision_3d
// Self-checking bench for the 3D elastic collision block. A directed table
// covers zero offset, zero masses, saturation and field extremes. Random
// collision pairs follow. Every result is compared against a known answer or an exact
// wide-integer prediction, in the order the items were accepted, while both
// channels idle and stall at random, until the last third holds rsp off and then runs flat out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_elastic_collision_3d;
   import ec3_pkg::*;

   localparam int NRAND   = 450;
   localparam int WDOG    = 4000;
   localparam int DRAIN   = 60;
   localparam int HOLDOFF = 300;

   typedef logic signed [299:0] wide_type;

   typedef struct {
      req_type item;
      logic    known;
      rsp_type answer;
   } vector_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type     velocity_q[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          send_idle = 11;
   int          recv_idle = 79;
   bit          hold_rsp = 1'b0;
   vector_type  vectors[$];

   elastic_collision_3d u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic wide_type round_div(input wide_type n, input wide_type d);
      wide_type a;
      wide_type q;
      a = n < 0 ? -n : n;
      q = (2 * a + d) / (2 * d);
      return n < 0 ? -q : q;
   endfunction

   function automatic logic [W-1:0] saturate(input wide_type v);
      if (v > wide_type'(64'sd2147483647)) return SMAX;
      if (v < -wide_type'(64'sd2147483648)) return SMIN;
      return v[W-1:0];
   endfunction

   function automatic rsp_type predict_velocities(input req_type r);
      rsp_type o;
      wide_type d[3], va[3], vb[3];
      wide_type ss, p, den, ca, cb, ma, mb;
      d[0] = wide_type'(r.offset_x);   d[1] = wide_type'(r.offset_y);
      d[2] = wide_type'(r.offset_z);
      va[0] = wide_type'(r.a_vel_x);   va[1] = wide_type'(r.a_vel_y);
      va[2] = wide_type'(r.a_vel_z);
      vb[0] = wide_type'(r.b_vel_x);   vb[1] = wide_type'(r.b_vel_y);
      vb[2] = wide_type'(r.b_vel_z);
      ma = wide_type'({1'b0, r.mass_a});
      mb = wide_type'({1'b0, r.mass_b});
      o.tag_out = r.pair_tag;
      o.new_a_vel_x = r.a_vel_x; o.new_a_vel_y = r.a_vel_y; o.new_a_vel_z = r.a_vel_z;
      o.new_b_vel_x = r.b_vel_x; o.new_b_vel_y = r.b_vel_y; o.new_b_vel_z = r.b_vel_z;
      ss = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      o.degenerate = (ss == 0);
      if (ss == 0 || ma + mb == 0) return o;
      p = d[0] * (vb[0] - va[0]) + d[1] * (vb[1] - va[1]) + d[2] * (vb[2] - va[2]);
      den = (ma + mb) * ss;
      ca = 2 * mb * p;
      cb = -(2 * ma * p);
      o.new_a_vel_x = saturate(va[0] + round_div(ca * d[0], den));
      o.new_a_vel_y = saturate(va[1] + round_div(ca * d[1], den));
      o.new_a_vel_z = saturate(va[2] + round_div(ca * d[2], den));
      o.new_b_vel_x = saturate(vb[0] + round_div(cb * d[0], den));
      o.new_b_vel_y = saturate(vb[1] + round_div(cb * d[1], den));
      o.new_b_vel_z = saturate(vb[2] + round_div(cb * d[2], den));
      return o;
   endfunction

   function automatic logic [W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? SMAX : SMIN;
         1: return W'($signed($urandom_range(0, 400)) - 200);
         2: return W'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [MASSW-1:0] rand_mass();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return MASSW'($urandom_range(0, 3));
         2: return MASSW'($urandom_range(32'h0000_8000, 32'h0004_0000));
         default: return MASSW'($urandom);
      endcase
   endfunction

   function automatic req_type rand_pair();
      req_type r;
      r.pair_tag = $urandom;
      r.offset_x = rand_word(); r.offset_y = rand_word(); r.offset_z = rand_word();
      if ($urandom_range(0, 19) == 0) begin
         r.offset_x = '0; r.offset_y = '0; r.offset_z = '0;
      end
      r.a_vel_x = rand_word(); r.a_vel_y = rand_word(); r.a_vel_z = rand_word();
      r.b_vel_x = rand_word(); r.b_vel_y = rand_word(); r.b_vel_z = rand_word();
      r.mass_a = rand_mass();
      r.mass_b = rand_mass();
      return r;
   endfunction

   function automatic req_type make_pair(input logic [31:0] tag, input logic [W-1:0] dx,
                                         input logic [W-1:0] dy, input logic [W-1:0] dz,
                                         input logic [W-1:0] av, input logic [W-1:0] bv,
                                         input logic [MASSW-1:0] ma,
                                         input logic [MASSW-1:0] mb);
      req_type r;
      r.pair_tag = tag;
      r.offset_x = dx; r.offset_y = dy; r.offset_z = dz;
      r.a_vel_x = av; r.a_vel_y = av; r.a_vel_z = av;
      r.b_vel_x = bv; r.b_vel_y = bv; r.b_vel_z = bv;
      r.mass_a = ma; r.mass_b = mb;
      return r;
   endfunction

   function automatic rsp_type passed(input req_type r, input logic degen);
      rsp_type o;
      o.tag_out = r.pair_tag;
      o.new_a_vel_x = r.a_vel_x; o.new_a_vel_y = r.a_vel_y; o.new_a_vel_z = r.a_vel_z;
      o.new_b_vel_x = r.b_vel_x; o.new_b_vel_y = r.b_vel_y; o.new_b_vel_z = r.b_vel_z;
      o.degenerate = degen;
      return o;
   endfunction

   task automatic add_row(input req_type r, input logic known, input rsp_type a);
      vector_type v;
      v.item = r; v.known = known; v.answer = a;
      vectors.push_back(v);
   endtask

   task automatic send_item(input req_type r);
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (velocity_q.size() == 0) begin
               $display("%0t unexpected result, actual %h", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== velocity_q[0]) begin
                  $display("%0t mismatch, expected %h, actual %h",
                           $time, velocity_q[0], rsp_data);
                  errors++;
               end
               void'(velocity_q.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WDOG) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_expected(input vector_type v);
      velocity_q.push_back(v.known ? v.answer : predict_velocities(v.item));
   endtask

   initial begin
      req_type    r;
      rsp_type    none;
      vector_type v;
      int         k;
      none = '0;
      r = make_pair(32'h0, '0, '0, '0, SMAX, SMIN, '1, '1);
      add_row(r, 1'b1, passed(r, 1'b1));
      r = make_pair(32'hffff_ffff, '0, '0, '0, SMIN, SMAX, 31'd1, 31'd1);
      add_row(r, 1'b1, passed(r, 1'b1));
      r = make_pair(32'h1234_5678, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 31'd0, 31'd0);
      add_row(r, 1'b1, passed(r, 1'b0));
      r = make_pair(32'h2, 32'h0001_0000, 0, 0, 32'h0001_0000, 0,
                    31'h0001_0000, 31'h0001_0000);
      add_row(r, 1'b0, none);
      r = make_pair(32'h3, SMAX, SMIN, SMAX, SMAX, SMIN, '1, '1);
      add_row(r, 1'b0, none);
      r = make_pair(32'h4, SMIN, SMIN, SMIN, SMIN, SMAX, 31'd1, '1);
      add_row(r, 1'b0, none);
      r = make_pair(32'h5, 1, 0, 0, SMIN, SMAX, 31'd0, 31'h10);
      add_row(r, 1'b0, none);
      r = make_pair(32'h6, 0, 1, 1, 32'h100, SMIN, 31'h5, 31'd0);
      add_row(r, 1'b0, none);
      r = make_pair(32'h7, SMAX, 1, SMIN, 3, 32'hffff_fffd, 31'd3, 31'd7);
      add_row(r, 1'b0, none);
      r = make_pair(32'h8, 32'hffff_ffff, 0, 0, SMAX, SMIN, '1, 31'd1);
      add_row(r, 1'b0, none);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         push_expected(vectors[i]);
         send_item(vectors[i].item);
      end
      for (k = 0; k < NRAND; k++) begin
         if (k == NRAND / 3) begin
            send_idle = 79; recv_idle = 11;
            req_valid <= 1'b0;
            do @(posedge clock); while (velocity_q.size() != 0);
         end
         if (k == 2 * NRAND / 3) begin
            send_idle = 0; recv_idle = 0;
            hold_rsp = 1'b1;
         end
         v.item = rand_pair(); v.known = 1'b0; v.answer = none;
         push_expected(v);
         send_item(v.item);
      end
      req_valid <= 1'b0;
      while (velocity_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && velocity_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      wait (hold_rsp);
      repeat (HOLDOFF) @(posedge clock);
      hold_rsp = 1'b0;
   end

endmodule
